### hw/rtl/heq_pkg.sv
`default_nettype none

package heq_pkg;

   // bin counter width, counts saturate at all ones
   localparam int COUNT_BITS = 24;

   localparam int PIX_W     = 8;
   localparam int BIN_COUNT = 1 << PIX_W;
   // running cdf over all bins never exceeds BIN_COUNT * (2^COUNT_BITS - 1)
   localparam int CDF_W     = COUNT_BITS + PIX_W;
   // cdf scaled by the top grey level
   localparam int NUM_W     = CDF_W + PIX_W;
   localparam int STEP_W    = $clog2(NUM_W);

   localparam logic [PIX_W-1:0]      BIN_LAST  = PIX_W'(BIN_COUNT - 1);
   localparam logic [PIX_W-1:0]      LEVEL_TOP = '1;
   localparam logic [COUNT_BITS-1:0] CNT_ONE   = COUNT_BITS'(1);
   localparam logic [STEP_W-1:0]     STEP_LAST = STEP_W'(NUM_W - 1);

   typedef enum logic [1:0] {
      KIND_CLEAR = 2'd0,
      KIND_COUNT = 2'd1,
      KIND_BUILD = 2'd2,
      KIND_MAP   = 2'd3
   } kind_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CNT_WR,
      ST_MAP_OUT,
      ST_BLD_RD,
      ST_BLD_ACC,
      ST_BLD_MUL,
      ST_BLD_DIV,
      ST_BLD_RND
   } state_type;

endpackage

`default_nettype wire

### hw/rtl/heq_div.sv
`default_nettype none

// restoring divider, one quotient bit per cycle
module heq_div (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   input  logic [heq_pkg::NUM_W-1:0]      numer,
   input  logic [heq_pkg::COUNT_BITS-1:0] denom,
   output logic                           done,
   output logic [heq_pkg::NUM_W-1:0]      quot,
   output logic [heq_pkg::COUNT_BITS-1:0] rem
);
   import heq_pkg::*;

   logic                  busy_ff, busy_in;
   logic                  done_ff, done_in;
   logic [STEP_W-1:0]     step_ff, step_in;
   logic [COUNT_BITS-1:0] rem_ff, rem_in;
   logic [NUM_W-1:0]      quot_ff, quot_in;
   logic [COUNT_BITS-1:0] denom_ff, denom_in;

   logic [COUNT_BITS:0]   shifted;
   logic [COUNT_BITS:0]   diff;
   logic                  ge;

   assign shifted = {rem_ff, quot_ff[NUM_W-1]};
   assign ge      = shifted >= {1'b0, denom_ff};
   assign diff    = shifted - {1'b0, denom_ff};

   always_comb begin
      busy_in  = busy_ff;
      done_in  = 1'b0;
      step_in  = step_ff;
      rem_in   = rem_ff;
      quot_in  = quot_ff;
      denom_in = denom_ff;
      if (start) begin
         busy_in  = 1'b1;
         step_in  = '0;
         rem_in   = '0;
         quot_in  = numer;
         denom_in = denom;
      end else if (busy_ff) begin
         rem_in  = ge ? diff[COUNT_BITS-1:0] : shifted[COUNT_BITS-1:0];
         quot_in = {quot_ff[NUM_W-2:0], ge};
         step_in = step_ff + STEP_W'(1);
         if (step_ff == STEP_LAST) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff   <= rem_in;
      quot_ff  <= quot_in;
      denom_ff <= denom_in;
   end

   assign done = done_ff;
   assign quot = quot_ff;
   assign rem  = rem_ff;

endmodule

`default_nettype wire

### hw/rtl/histogram_equalizer.sv
// histogram_equalizer: grey-level histogram equalization of 8-bit pixels
// request channel: req_valid / req_stall with req_kind and req_pixel, one word
//   is taken at a clock edge with req_valid high and req_stall low
//   kind clear: zeroes all bins and the total, done in the accept cycle
//   kind count: bumps the pixel's bin and the total, busy through ST_CNT_WR
//   kind build: walks 256 bins, one division on the shared divider per bin;
//     each bin steps through ST_BLD_RD, ST_BLD_ACC, ST_BLD_MUL, ST_BLD_DIV
//     and ST_BLD_RND, or ends at ST_BLD_MUL when the total is zero
//   kind map: busy in ST_MAP_OUT until the output register has room;
//     rsp_valid rises on the edge that leaves ST_MAP_OUT
// response channel: rsp_valid / rsp_stall, one word per map request only
// req_stall is high whenever the sequencer is busy; one request at a time
// the response sits in an output register, so a stalled response does not
// block the next request unless that request is another map
// reset clears the bins and total at once through per-bin valid bits; the
// level map is undefined until the first build
`default_nettype none

module histogram_equalizer (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  heq_pkg::kind_type         req_kind,
   input  logic [heq_pkg::PIX_W-1:0] req_pixel,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output logic [heq_pkg::PIX_W-1:0] rsp_mapped_pixel
);
   import heq_pkg::*;

   // sequencer state
   state_type             state_ff, state_in;
   // bin address for count and build
   logic [PIX_W-1:0]      idx_ff, idx_in;
   logic [CDF_W-1:0]      cdf_ff, cdf_in;
   logic [COUNT_BITS-1:0] total_ff, total_in;
   // a bin not marked valid reads as zero
   logic [BIN_COUNT-1:0]  bin_vld_ff, bin_vld_in;

   // histogram and level map memories, registered read
   logic [COUNT_BITS-1:0] bin_ram_ff [BIN_COUNT];
   logic [PIX_W-1:0]      map_ram_ff [BIN_COUNT];
   logic [COUNT_BITS-1:0] bin_rd_ff;
   logic [PIX_W-1:0]      map_rd_ff;

   // response output register
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [PIX_W-1:0]      rsp_data_ff, rsp_data_in;

   logic                  req_accept;
   logic [PIX_W-1:0]      bin_rd_addr;
   logic [COUNT_BITS-1:0] bin_val;
   logic [COUNT_BITS-1:0] bin_inc;
   logic [COUNT_BITS-1:0] total_inc;
   logic                  bin_wr_en;
   logic                  map_wr_en;
   logic [PIX_W-1:0]      map_wr_data;

   // shared divider
   logic                  div_start;
   logic                  div_done;
   logic [NUM_W-1:0]      div_numer;
   logic [NUM_W-1:0]      div_quot;
   logic [COUNT_BITS-1:0] div_rem;

   // rounding of the quotient
   logic [COUNT_BITS:0]   rem_x2;
   logic                  round_up;
   logic                  quot_big;
   logic [PIX_W-1:0]      level;

   assign req_stall  = (state_ff != ST_IDLE);
   assign req_accept = req_valid && !req_stall;

   // address comes straight from the request on accept, else from idx
   assign bin_rd_addr = (state_ff == ST_IDLE) ? req_pixel : idx_ff;
   assign bin_val     = bin_vld_ff[idx_ff] ? bin_rd_ff : '0;
   // saturating increments
   assign bin_inc     = (bin_val == '1) ? bin_val : bin_val + CNT_ONE;
   assign total_inc   = (total_ff == '1) ? total_ff : total_ff + CNT_ONE;

   // cdf * 255 as (cdf << 8) - cdf
   assign div_numer = {cdf_ff, {PIX_W{1'b0}}} - {{PIX_W{1'b0}}, cdf_ff};

   // round to nearest, ties to even, then clamp to the top level
   assign rem_x2   = {div_rem, 1'b0};
   assign round_up = (rem_x2 > {1'b0, total_ff})
                  || ((rem_x2 == {1'b0, total_ff}) && div_quot[0]);
   assign quot_big = (|div_quot[NUM_W-1:PIX_W]) || (div_quot[PIX_W-1:0] == LEVEL_TOP);
   assign level    = quot_big ? LEVEL_TOP
                              : div_quot[PIX_W-1:0] + {{(PIX_W-1){1'b0}}, round_up};

   heq_div u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .numer (div_numer),
      .denom (total_ff),
      .done  (div_done),
      .quot  (div_quot),
      .rem   (div_rem)
   );

   always_comb begin
      state_in     = state_ff;
      idx_in       = idx_ff;
      cdf_in       = cdf_ff;
      total_in     = total_ff;
      bin_vld_in   = bin_vld_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in  = rsp_data_ff;
      bin_wr_en    = 1'b0;
      map_wr_en    = 1'b0;
      map_wr_data  = level;
      div_start    = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               unique case (req_kind)
                  KIND_CLEAR: begin
                     bin_vld_in = '0;
                     total_in   = '0;
                  end
                  KIND_COUNT: begin
                     idx_in   = req_pixel;
                     state_in = ST_CNT_WR;
                  end
                  KIND_BUILD: begin
                     idx_in   = '0;
                     cdf_in   = '0;
                     state_in = ST_BLD_RD;
                  end
                  KIND_MAP: begin
                     state_in = ST_MAP_OUT;
                  end
               endcase
            end
         end
         ST_CNT_WR: begin
            bin_wr_en          = 1'b1;
            bin_vld_in[idx_ff] = 1'b1;
            total_in           = total_inc;
            state_in           = ST_IDLE;
         end
         ST_MAP_OUT: begin
            // wait for room in the output register
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = map_rd_ff;
               state_in     = ST_IDLE;
            end
         end
         ST_BLD_RD: begin
            state_in = ST_BLD_ACC;
         end
         ST_BLD_ACC: begin
            cdf_in   = cdf_ff + {{(CDF_W-COUNT_BITS){1'b0}}, bin_val};
            state_in = ST_BLD_MUL;
         end
         ST_BLD_MUL: begin
            if (total_ff == '0) begin
               // empty histogram maps everything to zero
               map_wr_en   = 1'b1;
               map_wr_data = '0;
               if (idx_ff == BIN_LAST) begin
                  state_in = ST_IDLE;
               end else begin
                  idx_in   = idx_ff + PIX_W'(1);
                  state_in = ST_BLD_RD;
               end
            end else begin
               div_start = 1'b1;
               state_in  = ST_BLD_DIV;
            end
         end
         ST_BLD_DIV: begin
            if (div_done) begin
               state_in = ST_BLD_RND;
            end
         end
         ST_BLD_RND: begin
            map_wr_en = 1'b1;
            if (idx_ff == BIN_LAST) begin
               state_in = ST_IDLE;
            end else begin
               idx_in   = idx_ff + PIX_W'(1);
               state_in = ST_BLD_RD;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         total_ff     <= '0;
         bin_vld_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         total_ff     <= total_in;
         bin_vld_ff   <= bin_vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff      <= idx_in;
      cdf_ff      <= cdf_in;
      rsp_data_ff <= rsp_data_in;
   end

   // histogram memory: one read, one write port
   always_ff @(posedge clock) begin
      if (bin_wr_en) begin
         bin_ram_ff[idx_ff] <= bin_inc;
      end
      bin_rd_ff <= bin_ram_ff[bin_rd_addr];
   end

   // level map memory: read on every request accept, written during build
   always_ff @(posedge clock) begin
      if (map_wr_en) begin
         map_ram_ff[idx_ff] <= map_wr_data;
      end
      if (req_accept) begin
         map_rd_ff <= map_ram_ff[req_pixel];
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_mapped_pixel = rsp_data_ff;

   // a new response word only comes out of the map output state
   a_rsp_from_map: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_MAP_OUT))
      else $error("response word raised outside map output");

   // divider only finishes while the sequencer waits on it
   a_div_owned: assert property (@(posedge clock) disable iff (reset)
      div_done |-> (state_ff == ST_BLD_DIV))
      else $error("divider done outside divide wait");

   // the build ends after the last bin
   a_build_end: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_BLD_RND && idx_ff == BIN_LAST) |=> (state_ff == ST_IDLE))
      else $error("build did not end after last bin");

   // cdf holds while a division is running on it
   a_cdf_hold: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_BLD_DIV) |=> $stable(cdf_ff))
      else $error("cdf changed during divide");

endmodule

`default_nettype wire

### tb/testbench.sv
`default_nettype none

module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   import heq_pkg::*;

   // stimulus size and time limits
   localparam int WORDS_TOTAL    = 1700;
   localparam int QUIET_TAIL     = 200;     // last words run with no idling
   localparam int LONG_HOLD      = 300;     // receiver hold-off in cycles
   localparam int WATCHDOG_LIMIT = 60000;   // long enough to span one build
   localparam int TAIL_CYCLES    = 32;

   localparam logic [COUNT_BITS-1:0] COUNT_TOP = '1;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic             req_valid = 1'b0;
   logic             req_stall;
   kind_type         req_kind  = KIND_CLEAR;
   logic [PIX_W-1:0] req_pixel = '0;
   logic             rsp_valid;
   logic             rsp_stall = 1'b0;
   logic [PIX_W-1:0] rsp_mapped_pixel;

   histogram_equalizer dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_kind         (req_kind),
      .req_pixel        (req_pixel),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_mapped_pixel (rsp_mapped_pixel)
   );

   always #4 clock = ~clock;

   // ------------------------------------------------------------------
   // equalizer shadow: histogram, pixel total and level lookup table
   // ------------------------------------------------------------------
   logic [COUNT_BITS-1:0] hist_bins [BIN_COUNT];
   logic [COUNT_BITS-1:0] pixel_total;
   logic [PIX_W-1:0]      level_lut [BIN_COUNT];
   bit                    lut_written;

   // mapped pixels still owed by the block, oldest first
   logic [PIX_W-1:0] pending_levels [$];

   int errors         = 0;
   int words_sent     = 0;
   int builds_run     = 0;
   int empty_builds   = 0;
   int levels_checked = 0;
   int stuck_cycles   = 0;

   bit quiet       = 1'b0;   // no idling on either side
   bit hold_req    = 1'b0;   // ask the receiver for one long hold-off
   bit hold_active = 1'b0;

   // round(cdf * 255 / total) with ties to even, clipped at the top level
   function automatic logic [PIX_W-1:0] equalized_level(longint unsigned cdf,
                                                        longint unsigned total);
      longint unsigned num, q, r;
      if (total == 0) return '0;
      num = cdf * 255;
      q = num / total;
      r = num % total;
      if (2 * r > total || (2 * r == total && q[0])) q++;
      if (q > 255) q = 255;
      return q[PIX_W-1:0];
   endfunction

   function automatic void rebuild_levels();
      longint unsigned cdf;
      cdf = 0;
      for (int i = 0; i < BIN_COUNT; i++) begin
         cdf += hist_bins[i];
         level_lut[i] = equalized_level(cdf, pixel_total);
      end
      lut_written = 1'b1;
   endfunction

   // update the shadow for one accepted word; a map word owes a level
   function automatic void shadow_word(kind_type kind, logic [PIX_W-1:0] pixel,
                                       bit typed, logic [PIX_W-1:0] typed_level);
      case (kind)
         KIND_CLEAR: begin
            foreach (hist_bins[i]) hist_bins[i] = '0;
            pixel_total = '0;
         end
         KIND_COUNT: begin
            if (hist_bins[pixel] != COUNT_TOP) hist_bins[pixel]++;
            if (pixel_total != COUNT_TOP) pixel_total++;
         end
         KIND_BUILD: begin
            builds_run++;
            if (pixel_total == 0) empty_builds++;
            rebuild_levels();
         end
         KIND_MAP: begin
            pending_levels.push_back(typed ? typed_level : level_lut[pixel]);
         end
      endcase
   endfunction

   // ------------------------------------------------------------------
   // request side
   // ------------------------------------------------------------------
   // offer one word and hold it until taken; valid stays high on return
   task automatic send_word(kind_type kind, logic [PIX_W-1:0] pixel,
                            bit typed = 1'b0, logic [PIX_W-1:0] typed_level = '0);
      req_valid <= 1'b1;
      req_kind  <= kind;
      req_pixel <= pixel;
      forever begin
         @(posedge clock);
         if (!req_stall) break;
      end
      shadow_word(kind, pixel, typed, typed_level);
      words_sent++;
      quiet = (words_sent >= WORDS_TOTAL - QUIET_TAIL);
   endtask

   // random idle burst between words
   task automatic maybe_gap();
      if (!quiet && $urandom_range(0, 5) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 14)) @(posedge clock);
      end
   endtask

   // wait for every owed level to come back, valid held low
   task automatic drain_levels();
      req_valid <= 1'b0;
      while (pending_levels.size() != 0) @(posedge clock);
   endtask

   // pixel for a count word: mostly a narrow band, as in a low-contrast image
   function automatic logic [PIX_W-1:0] band_pixel(int base, int spread);
      int p;
      p = base + $urandom_range(0, spread);
      return (p > 255) ? 8'd255 : PIX_W'(p);
   endfunction

   typedef struct {
      kind_type         kind;
      logic [PIX_W-1:0] pixel;
      bit               typed;
      logic [PIX_W-1:0] level;
   } stim_row_type;

   // directed words; typed levels are the ones readable by hand
   stim_row_type opening_rows [24] = '{
      '{KIND_CLEAR, 8'h00, 1'b0, 8'h00},
      '{KIND_BUILD, 8'hFF, 1'b0, 8'h00},   // empty histogram, all-zero map
      '{KIND_MAP,   8'h00, 1'b1, 8'h00},
      '{KIND_MAP,   8'hFF, 1'b1, 8'h00},
      '{KIND_COUNT, 8'h00, 1'b0, 8'h00},
      '{KIND_BUILD, 8'h00, 1'b0, 8'h00},   // one pixel: every level at the top
      '{KIND_MAP,   8'h00, 1'b1, 8'hFF},
      '{KIND_MAP,   8'hFF, 1'b1, 8'hFF},
      '{KIND_COUNT, 8'hFF, 1'b0, 8'h00},
      '{KIND_BUILD, 8'h55, 1'b0, 8'h00},   // 127.5 rounds to even 128
      '{KIND_MAP,   8'h00, 1'b1, 8'h80},
      '{KIND_MAP,   8'h7F, 1'b1, 8'h80},
      '{KIND_MAP,   8'hFF, 1'b1, 8'hFF},
      '{KIND_CLEAR, 8'hAA, 1'b0, 8'h00},   // clear keeps the level map
      '{KIND_MAP,   8'h00, 1'b1, 8'h80},
      '{KIND_COUNT, 8'h55, 1'b0, 8'h00},
      '{KIND_COUNT, 8'hAA, 1'b0, 8'h00},
      '{KIND_COUNT, 8'hAA, 1'b0, 8'h00},
      '{KIND_BUILD, 8'h00, 1'b0, 8'h00},   // thirds: 0, 85, 255
      '{KIND_MAP,   8'h00, 1'b1, 8'h00},
      '{KIND_MAP,   8'h64, 1'b1, 8'h55},
      '{KIND_MAP,   8'hC8, 1'b1, 8'hFF},
      '{KIND_COUNT, 8'h01, 1'b0, 8'h00},   // count without a rebuild
      '{KIND_MAP,   8'h55, 1'b0, 8'h00}
   };

   initial begin
      int frame, n_counts, n_maps, base, spread;
      kind_type k;

      foreach (hist_bins[i]) hist_bins[i] = '0;
      foreach (level_lut[i]) level_lut[i] = '0;
      pixel_total = '0;
      lut_written = 1'b0;

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      foreach (opening_rows[i]) begin
         maybe_gap();
         send_word(opening_rows[i].kind, opening_rows[i].pixel,
                   opening_rows[i].typed, opening_rows[i].level);
      end

      // random frames: mostly clear, count a picture, build, map pixels
      frame = 0;
      while (words_sent < WORDS_TOTAL) begin
         if (frame > 6 && $urandom_range(0, 5) == 0) begin
            // noise: loose words in any order, no rebuild
            repeat ($urandom_range(4, 12)) begin
               k = kind_type'($urandom_range(0, 3));
               if (k == KIND_BUILD || (k == KIND_MAP && !lut_written)) k = KIND_COUNT;
               maybe_gap();
               send_word(k, PIX_W'($urandom));
            end
         end else begin
            // sometimes keep the old histogram and pile more pixels on it
            if (frame < 2 || $urandom_range(0, 3) != 0) begin
               maybe_gap();
               send_word(KIND_CLEAR, PIX_W'($urandom));
            end
            // empty picture now and then
            n_counts = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 60);
            base     = $urandom_range(0, 255);
            spread   = ($urandom_range(0, 2) == 0) ? 255 : $urandom_range(0, 40);
            repeat (n_counts) begin
               maybe_gap();
               send_word(KIND_COUNT, band_pixel(base, spread));
            end
            maybe_gap();
            send_word(KIND_BUILD, PIX_W'($urandom));

            n_maps = $urandom_range(8, 50);
            if (frame == 2) begin
               // long receiver hold-off: the output register fills and the
               // request side backs up while the sender keeps offering maps
               n_maps = 40;
               req_valid <= 1'b0;
               hold_req = 1'b1;
               while (!hold_active) @(posedge clock);
            end
            repeat (n_maps) begin
               maybe_gap();
               send_word(KIND_MAP, PIX_W'($urandom));
            end
            // sender pause until every owed level has arrived
            if (frame == 5) drain_levels();
         end
         frame++;
      end

      drain_levels();
      repeat (TAIL_CYCLES) @(posedge clock);

      $display("summary: %0d words, %0d map builds (%0d on an empty histogram)",
               words_sent, builds_run, empty_builds);
      $display("summary: %0d mapped pixels checked, %0d mismatches", levels_checked, errors);
      if (errors == 0) begin
         $display("testbench: done, clean");
      end else begin
         $display("testbench: done, errors");
      end
      $finish;
   end

   // ------------------------------------------------------------------
   // response side: random stall bursts, one long hold-off on request
   // ------------------------------------------------------------------
   initial begin
      @(posedge clock);
      forever begin
         if (hold_req) begin
            rsp_stall <= 1'b1;
            hold_active = 1'b1;
            repeat (LONG_HOLD) @(posedge clock);
            hold_req    = 1'b0;
            hold_active = 1'b0;
         end else if (!quiet && $urandom_range(0, 2) == 0) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 14)) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         repeat ($urandom_range(1, 24)) @(posedge clock);
      end
   end

   // compare each taken word with the oldest owed level
   logic [PIX_W-1:0] owed_level;

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_levels.size() == 0) begin
            $display("%0t: mapped_pixel with none owed, expected nothing, got %0d",
                     $time, rsp_mapped_pixel);
            errors++;
         end else begin
            owed_level = pending_levels.pop_front();
            levels_checked++;
            if (rsp_mapped_pixel !== owed_level) begin
               $display("%0t: mapped_pixel mismatch, expected %0d, got %0d",
                        $time, owed_level, rsp_mapped_pixel);
               errors++;
            end
         end
      end
   end

   // watchdog: cycles with no word taken on either channel
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         stuck_cycles = 0;
      end else begin
         stuck_cycles++;
         if (stuck_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: no word moved for %0d cycles, %0d levels still owed",
                     $time, stuck_cycles, pending_levels.size());
            $display("testbench: done, errors");
            $finish;
         end
      end
   end

endmodule

`default_nettype wire
